>>> rtl/grc_pkg.sv
// grc_pkg: shared types and constants for the greedy rectangle cover block
// no dependencies; used by every file under rtl but grc_ram
package grc_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 7;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 4'd1;

  localparam logic [6:0] GRID_WIDTH_RESET  = 7'd64;
  localparam logic [6:0] GRID_HEIGHT_RESET = 7'd64;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       solid;
  } grc_in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] rect_col;
    logic [5:0] rect_row;
    logic [6:0] rect_width;
    logic [6:0] rect_height;
  } grc_out_t;

  // grid extent in use after clamping
  typedef struct packed {
    logic [6:0] w_use;
    logic [6:0] h_use;
  } grc_limits_t;

  // load strobes for the span unit
  typedef struct packed {
    logic take_f;
    logic take_low;
    logic take_run;
  } grc_span_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WB,
    ST_SCAN,
    ST_LOW,
    ST_RUN,
    ST_EXT,
    ST_MARK,
    ST_RQ_WB
  } grc_state_t;

endpackage

>>> rtl/grc_ram.sv
// grc_ram: one write port, one read port memory with registered read data
// no dependencies
module grc_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/grc_cfg.sv
// grc_cfg: grid extent registers and their clamped values
// depends on grc_pkg
module grc_cfg #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [grc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output grc_pkg::grc_limits_t             limits
);

  logic [6:0] grid_width;
  logic [6:0] grid_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= grc_pkg::GRID_WIDTH_RESET;
      grid_height <= grc_pkg::GRID_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        grc_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        grc_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above storage acts as the storage size
  always_comb begin
    if (grid_width == 7'd0) begin
      limits.w_use = 7'd1;
    end else if ({2'b00, grid_width} > 9'(MAX_COLS)) begin
      limits.w_use = 7'(MAX_COLS);
    end else begin
      limits.w_use = grid_width;
    end
    if (grid_height == 7'd0) begin
      limits.h_use = 7'd1;
    end else if ({2'b00, grid_height} > 9'(MAX_ROWS)) begin
      limits.h_use = 7'(MAX_ROWS);
    end else begin
      limits.h_use = grid_height;
    end
  end

endmodule

>>> rtl/grc_span.sv
// grc_span: finds the first free run in a masked row word in registered steps
// depends on grc_pkg
module grc_span #(
  parameter int COLS = 64
) (
  input  logic                  clk,
  input  grc_pkg::grc_span_ctl_t ctl,
  input  logic [COLS-1:0]       f,
  output logic [COLS-1:0]       run,
  output logic [5:0]            x_col,
  output logic [6:0]            end_col
);

  logic [COLS-1:0] f_reg;
  logic [COLS-1:0] lowbit;
  logic [COLS:0]   endhot;
  logic [COLS:0]   sum;

  function automatic logic [5:0] enc_low(input logic [COLS-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < COLS; i++) begin
      if (v[i]) idx = idx | 6'(i);
    end
    return idx;
  endfunction

  function automatic logic [6:0] enc_end(input logic [COLS:0] v);
    logic [6:0] idx;
    idx = '0;
    for (int i = 0; i <= COLS; i++) begin
      if (v[i]) idx = idx | 7'(i);
    end
    return idx;
  endfunction

  // adding the lowest bit ripples through the run and lands just past it
  assign sum = {1'b0, f_reg} + {1'b0, lowbit};

  always_ff @(posedge clk) begin
    if (ctl.take_f) begin
      f_reg <= f;
    end
    if (ctl.take_low) begin
      lowbit <= f_reg & ((~f_reg) + COLS'(1));
    end
    if (ctl.take_run) begin
      run    <= f_reg & ~sum[COLS-1:0];
      endhot <= sum & ~{1'b0, f_reg};
      x_col  <= enc_low(lowbit);
    end
  end

  assign end_col = enc_end(endhot);

endmodule

>>> rtl/greedy_rect_cover_top.sv
// greedy_rect_cover_top: greedy rectangle cover over a free-cell row memory
// load: busy in ST_LD_WB, the write-back after the accepting edge, no result
// request: done in the cycle after accept if the cursor is past the grid, else
//   ST_SCAN per row till a free cell (done if none), ST_LOW, ST_RUN, ST_EXT rows
//   below, ST_MARK rows, ST_RQ_WB; one row word a cycle via the single read port
// sync reset clears control state and the cursor; the memory is not cleared
module greedy_rect_cover_top #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  grc_pkg::grc_in_t                item,
  output logic                            done,
  output grc_pkg::grc_out_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [grc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  grc_pkg::grc_state_t    state, state_next;
  grc_pkg::grc_limits_t   limits;
  grc_pkg::grc_span_ctl_t span_ctl;

  // each memory word holds solid and not yet used, one bit per column
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [MAX_COLS-1:0] rdata;
  logic                wb_pend;
  logic [AW-1:0]       wb_addr;
  logic [MAX_COLS-1:0] wb_clr;
  logic [MAX_COLS-1:0] wb_set;
  logic [MAX_COLS-1:0] wdata;

  logic [6:0] scan_row;
  logic [5:0] scan_col;
  logic [6:0] cur_row;
  logic [5:0] start_col;
  logic [6:0] ext_row;
  logic [6:0] hgt;
  logic [6:0] mk;

  logic [MAX_COLS-1:0] scan_word;
  logic [MAX_COLS-1:0] col_bit;
  logic [MAX_COLS-1:0] run;
  logic [5:0]          x_col;
  logic [6:0]          end_col;
  logic                accept;
  logic                load_ok;
  logic                span_ok;
  logic [6:0]          nxt_row;
  logic [6:0]          nxt_ext;

  grc_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  grc_ram #(
    .DEPTH  (MAX_ROWS),
    .WIDTH  (MAX_COLS),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wb_pend),
    .waddr (wb_addr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  grc_span #(
    .COLS (MAX_COLS)
  ) u_span (
    .clk     (clk),
    .ctl     (span_ctl),
    .f       (scan_word),
    .run     (run),
    .x_col   (x_col),
    .end_col (end_col)
  );

  assign busy    = (state != grc_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign load_ok = ({1'b0, item.cell_col} < 7'(MAX_COLS)) &&
                   ({3'b000, item.cell_row} < 9'(MAX_ROWS));
  assign span_ok = ((rdata & run) == run);
  assign nxt_row = cur_row + 7'd1;
  assign nxt_ext = ext_row + 7'd1;
  // the write-back always modifies the word read in the cycle before
  assign wdata   = (rdata & ~wb_clr) | wb_set;

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_bit[i]   = ({1'b0, item.cell_col} == 7'(i));
      scan_word[i] = rdata[i] && (7'(i) >= {1'b0, start_col}) && (7'(i) < limits.w_use);
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = AW'(cur_row);
    span_ctl   = '0;
    case (state)
      grc_pkg::ST_IDLE: begin
        if (accept) begin
          if (item.kind == grc_pkg::KIND_LOAD) begin
            if (load_ok) begin
              rd_en      = 1'b1;
              rd_addr    = AW'(item.cell_row);
              state_next = grc_pkg::ST_LD_WB;
            end
          end else if (scan_row < limits.h_use) begin
            rd_en      = 1'b1;
            rd_addr    = AW'(scan_row);
            state_next = grc_pkg::ST_SCAN;
          end
        end
      end
      grc_pkg::ST_LD_WB: begin
        state_next = grc_pkg::ST_IDLE;
      end
      grc_pkg::ST_SCAN: begin
        if (scan_word != '0) begin
          span_ctl.take_f = 1'b1;
          state_next      = grc_pkg::ST_LOW;
        end else if (nxt_row < limits.h_use) begin
          rd_en   = 1'b1;
          rd_addr = AW'(nxt_row);
        end else begin
          state_next = grc_pkg::ST_IDLE;
        end
      end
      grc_pkg::ST_LOW: begin
        span_ctl.take_low = 1'b1;
        state_next        = grc_pkg::ST_RUN;
      end
      grc_pkg::ST_RUN: begin
        span_ctl.take_run = 1'b1;
        if (nxt_row < limits.h_use) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(nxt_row);
          state_next = grc_pkg::ST_EXT;
        end else begin
          state_next = grc_pkg::ST_MARK;
        end
      end
      grc_pkg::ST_EXT: begin
        if (span_ok && (nxt_ext < limits.h_use)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(nxt_ext);
        end else begin
          state_next = grc_pkg::ST_MARK;
        end
      end
      grc_pkg::ST_MARK: begin
        rd_en   = 1'b1;
        rd_addr = AW'(mk);
        if ((mk + 7'd1) == (cur_row + hgt)) begin
          state_next = grc_pkg::ST_RQ_WB;
        end
      end
      grc_pkg::ST_RQ_WB: begin
        state_next = grc_pkg::ST_IDLE;
      end
      default: begin
        state_next = grc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_pend  <= 1'b0;
      done     <= 1'b0;
      scan_row <= '0;
      scan_col <= '0;
    end else begin
      wb_pend <= 1'b0;
      done    <= 1'b0;
      case (state)
        grc_pkg::ST_IDLE: begin
          if (accept) begin
            if (item.kind == grc_pkg::KIND_LOAD) begin
              if (load_ok) begin
                wb_pend  <= 1'b1;
                scan_row <= '0;
                scan_col <= '0;
              end
            end else if (scan_row >= limits.h_use) begin
              done     <= 1'b1;
              scan_row <= limits.h_use;
              scan_col <= '0;
            end
          end
        end
        grc_pkg::ST_SCAN: begin
          if ((scan_word == '0) && (nxt_row >= limits.h_use)) begin
            done     <= 1'b1;
            scan_row <= limits.h_use;
            scan_col <= '0;
          end
        end
        grc_pkg::ST_MARK: begin
          wb_pend <= 1'b1;
        end
        grc_pkg::ST_RQ_WB: begin
          done <= 1'b1;
          if (end_col >= limits.w_use) begin
            scan_row <= cur_row + 7'd1;
            scan_col <= '0;
          end else begin
            scan_row <= cur_row;
            scan_col <= end_col[5:0];
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      grc_pkg::ST_IDLE: begin
        if (accept) begin
          if (item.kind == grc_pkg::KIND_LOAD) begin
            wb_addr <= AW'(item.cell_row);
            wb_clr  <= col_bit;
            wb_set  <= item.solid ? col_bit : '0;
          end else begin
            cur_row   <= scan_row;
            start_col <= scan_col;
            result    <= '0;
          end
        end
      end
      grc_pkg::ST_SCAN: begin
        if (scan_word == '0) begin
          cur_row   <= nxt_row;
          start_col <= '0;
          result    <= '0;
        end
      end
      grc_pkg::ST_RUN: begin
        hgt     <= 7'd1;
        ext_row <= nxt_row;
        mk      <= cur_row;
      end
      grc_pkg::ST_EXT: begin
        if (span_ok) begin
          hgt     <= hgt + 7'd1;
          ext_row <= nxt_ext;
        end
      end
      grc_pkg::ST_MARK: begin
        wb_addr <= AW'(mk);
        wb_clr  <= run;
        wb_set  <= '0;
        mk      <= mk + 7'd1;
      end
      grc_pkg::ST_RQ_WB: begin
        result.found       <= 1'b1;
        result.rect_col    <= x_col;
        result.rect_row    <= cur_row[5:0];
        result.rect_width  <= end_col - {1'b0, x_col};
        result.rect_height <= hgt;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/grc_checker.sv
// grc_checker: port-level properties of the rectangle cover top level
// depends on grc_pkg; bound to greedy_rect_cover_top below
module grc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input grc_pkg::grc_in_t  item,
  input logic              done,
  input grc_pkg::grc_out_t result
);

  // a result beat only ever comes out while the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.kind == grc_pkg::KIND_LOAD)) |=> !done)
    else $error("load produced a result beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |->
      (result.rect_col == 6'd0) && (result.rect_row == 6'd0) &&
      (result.rect_width == 7'd0) && (result.rect_height == 7'd0))
    else $error("empty result carries a rectangle");

  a_hit_size: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.rect_width != 7'd0) && (result.rect_height != 7'd0))
    else $error("found rectangle has zero size");

endmodule

bind greedy_rect_cover_top grc_checker u_grc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

>>> test/greedy_rect_cover_top_tb.sv
// greedy_rect_cover_top_tb: self-checking bench for the greedy rectangle cover block
// drives load and request beats, predicts every rectangle and compares each result beat
// depends on rtl/grc_pkg.sv and rtl/greedy_rect_cover_top.sv
`timescale 1ns / 100ps

module greedy_rect_cover_top_tb;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 64;
  localparam int BLOCK       = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 42;
  localparam int SETTLE      = 4;
  localparam logic [grc_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 4'd5;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  grc_pkg::grc_in_t                item;
  logic                            done;
  grc_pkg::grc_out_t               result;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [grc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [grc_pkg::CFG_DATA_W-1:0]  cfg_data;

  // predicted grid state
  logic [63:0] solid_map [GRID_ROWS];
  logic [63:0] used_map  [GRID_ROWS];
  logic [5:0]  cursor_col;
  logic [6:0]  cursor_row;
  logic [6:0]  reg_width;
  logic [6:0]  reg_height;

  grc_pkg::grc_out_t expected_rects [$];
  int                mismatches;
  int                items_sent;
  int                burst_left;
  int                cycle_count = 0;

  greedy_rect_cover_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_extent(input logic [6:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic bit is_free(input int r, input int c);
    if (r >= GRID_ROWS || c >= GRID_COLS) return 1'b0;
    return solid_map[r][c] && !used_map[r][c];
  endfunction

  // advances the predicted grid by one beat; returns 1 when a result beat follows
  function automatic bit cover_step(input grc_pkg::grc_in_t it,
                                    output grc_pkg::grc_out_t rect);
    int  w_use, h_use, r, c, x, y, w, h;
    bit  hit, ok;
    rect = '0;
    if (it.kind == grc_pkg::KIND_LOAD) begin
      solid_map[it.cell_row][it.cell_col] = it.solid;
      used_map[it.cell_row][it.cell_col]  = 1'b0;
      cursor_col = '0;
      cursor_row = '0;
      return 1'b0;
    end
    w_use = clamp_extent(reg_width, GRID_COLS);
    h_use = clamp_extent(reg_height, GRID_ROWS);
    hit = 1'b0;
    x = 0;
    y = 0;
    for (r = int'(cursor_row); r < h_use && !hit; r++) begin
      for (c = (r == int'(cursor_row)) ? int'(cursor_col) : 0; c < w_use && !hit; c++) begin
        if (is_free(r, c)) begin
          x = c;
          y = r;
          hit = 1'b1;
        end
      end
    end
    if (!hit) begin
      cursor_row = 7'(h_use);
      cursor_col = '0;
      return 1'b1;
    end
    w = 0;
    while (x + w < w_use && is_free(y, x + w)) w++;
    h = 1;
    while (y + h < h_use) begin
      ok = 1'b1;
      for (c = 0; c < w; c++) begin
        if (!is_free(y + h, x + c)) ok = 1'b0;
      end
      if (!ok) break;
      h++;
    end
    for (r = y; r < y + h; r++) begin
      for (c = x; c < x + w; c++) used_map[r][c] = 1'b1;
    end
    if (x + w >= w_use) begin
      cursor_col = '0;
      cursor_row = 7'(y + 1);
    end else begin
      cursor_col = 6'(x + w);
      cursor_row = 7'(y);
    end
    rect.found       = 1'b1;
    rect.rect_col    = 6'(x);
    rect.rect_row    = 6'(y);
    rect.rect_width  = 7'(w);
    rect.rect_height = 7'(h);
    return 1'b1;
  endfunction

  function automatic grc_pkg::grc_in_t load_item(input int col, input int row,
                                                 input logic solid);
    grc_pkg::grc_in_t it;
    it.kind     = grc_pkg::KIND_LOAD;
    it.cell_col = 6'(col);
    it.cell_row = 6'(row);
    it.solid    = solid;
    return it;
  endfunction

  // position and solid bits are don't-care on a request, so they toggle freely
  function automatic grc_pkg::grc_in_t request_item();
    logic [31:0]      raw;
    grc_pkg::grc_in_t it;
    raw     = $urandom;
    it      = raw[$bits(grc_pkg::grc_in_t)-1:0];
    it.kind = grc_pkg::KIND_REQUEST;
    return it;
  endfunction

  // one beat; start stays high afterwards so a burst runs back to back
  task automatic send_item(input grc_pkg::grc_in_t it);
    int                gap;
    grc_pkg::grc_out_t rect;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    burst_left--;
    items_sent++;
    if (cover_step(it, rect)) expected_rects = {expected_rects, rect};
  endtask

  // sender holds off until every result has come and a load has had time to land
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [grc_pkg::CFG_INDEX_W-1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == grc_pkg::CFG_GRID_WIDTH) reg_width = val;
    else if (idx == grc_pkg::CFG_GRID_HEIGHT) reg_height = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    grc_pkg::grc_out_t want;
    if (!rst && done) begin
      if (expected_rects.size() == 0) begin
        $error("result beat with nothing expected: %p", result);
        mismatches++;
      end else begin
        want = expected_rects.pop_front();
        check_field("found", 7'(want.found), 7'(result.found));
        check_field("rect_col", 7'(want.rect_col), 7'(result.rect_col));
        check_field("rect_row", 7'(want.rect_row), 7'(result.rect_row));
        check_field("rect_width", want.rect_width, result.rect_width);
        check_field("rect_height", want.rect_height, result.rect_height);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // every cell a later scan reaches is written first: the corner block, row 0 and column 0
  task automatic test_fill_grid();
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        if ((r < BLOCK && c < BLOCK) || r == 0 || c == 0) send_item(load_item(c, r, 1'b1));
      end
    end
  endtask

  // corner block solid: one block-sized rectangle, then nothing left twice over
  task automatic test_whole_cover();
    wait_idle();
    write_reg(grc_pkg::CFG_GRID_WIDTH, 7'(BLOCK));
    write_reg(grc_pkg::CFG_GRID_HEIGHT, 7'(BLOCK));
    repeat (3) send_item(request_item());
  endtask

  task automatic test_corner_cells();
    send_item(load_item(BLOCK - 1, BLOCK - 1, 1'b1));
    send_item(request_item());
    send_item(load_item(0, 0, 1'b0));
    send_item(load_item(1, 0, 1'b1));
    send_item(load_item(1, 1, 1'b1));
    send_item(request_item());
    send_item(request_item());
  endtask

  // zero and oversized register values, plus a write to an unmapped index
  task automatic test_register_limits();
    wait_idle();
    write_reg(grc_pkg::CFG_GRID_WIDTH, 7'd0);
    write_reg(grc_pkg::CFG_GRID_HEIGHT, 7'd0);
    send_item(load_item(0, 0, 1'b1));
    send_item(request_item());
    send_item(request_item());
    wait_idle();
    write_reg(grc_pkg::CFG_GRID_WIDTH, 7'd127);
    write_reg(grc_pkg::CFG_GRID_HEIGHT, 7'd0);
    write_reg(CFG_UNMAPPED, 7'd3);
    send_item(load_item(62, 0, 1'b1));
    send_item(load_item(63, 0, 1'b1));
    send_item(request_item());
    send_item(request_item());
    wait_idle();
    write_reg(grc_pkg::CFG_GRID_WIDTH, 7'd0);
    write_reg(grc_pkg::CFG_GRID_HEIGHT, 7'd127);
    send_item(request_item());
    send_item(request_item());
  endtask

  // cursor left mid-row, then the width shrinks below it
  task automatic test_cursor_past_width();
    wait_idle();
    write_reg(grc_pkg::CFG_GRID_WIDTH, 7'(BLOCK));
    write_reg(grc_pkg::CFG_GRID_HEIGHT, 7'(BLOCK));
    send_item(load_item(4, 2, 1'b1));
    send_item(load_item(5, 2, 1'b1));
    send_item(load_item(6, 2, 1'b1));
    send_item(load_item(0, 3, 1'b1));
    send_item(request_item());
    wait_idle();
    write_reg(grc_pkg::CFG_GRID_WIDTH, 7'd4);
    send_item(request_item());
  endtask

  // mostly solid patches followed by requests, with stray loads and bare requests
  task automatic test_random_covers();
    logic [6:0] w_set [7];
    logic [6:0] h_set [7];
    int         phase_start, w_use, h_use, x, y, rw, rh, pick;
    w_set = '{7'(BLOCK), 7'd1, 7'd64, 7'd127, 7'd0, 7'd0, 7'(BLOCK)};
    h_set = '{7'(BLOCK), 7'd64, 7'd1, 7'd0, 7'd127, 7'd0, 7'(BLOCK)};
    w_set[5] = 7'($urandom_range(2, BLOCK));
    h_set[5] = 7'($urandom_range(2, BLOCK));
    foreach (w_set[p]) begin
      wait_idle();
      write_reg(grc_pkg::CFG_GRID_WIDTH, w_set[p]);
      write_reg(grc_pkg::CFG_GRID_HEIGHT, h_set[p]);
      w_use = clamp_extent(reg_width, GRID_COLS);
      h_use = clamp_extent(reg_height, GRID_ROWS);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          x = $urandom_range(0, w_use - 1);
          y = $urandom_range(0, h_use - 1);
          if ($urandom_range(0, 11) == 0) begin
            rw = w_use - x;
            rh = 1;
          end else begin
            rw = $urandom_range(1, (w_use - x < 4) ? w_use - x : 4);
            rh = $urandom_range(1, (h_use - y < 4) ? h_use - y : 4);
          end
          for (int r = y; r < y + rh; r++) begin
            for (int c = x; c < x + rw; c++) send_item(load_item(c, r, 1'b1));
          end
          if ($urandom_range(0, 1) == 1)
            send_item(load_item($urandom_range(0, w_use - 1), $urandom_range(0, h_use - 1),
                                1'b0));
          repeat ($urandom_range(1, 3)) send_item(request_item());
        end else if (pick < 8) begin
          send_item(load_item($urandom_range(0, 63), $urandom_range(0, 63),
                              1'($urandom_range(0, 1))));
        end else begin
          send_item(request_item());
        end
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    item        <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    mismatches   = 0;
    items_sent   = 0;
    burst_left   = 0;
    cursor_col   = '0;
    cursor_row   = '0;
    reg_width    = grc_pkg::GRID_WIDTH_RESET;
    reg_height   = grc_pkg::GRID_HEIGHT_RESET;
    for (int r = 0; r < GRID_ROWS; r++) begin
      solid_map[r] = '0;
      used_map[r]  = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_fill_grid();
    test_whole_cover();
    test_corner_cells();
    test_register_limits();
    test_cursor_past_width();
    test_random_covers();

    wait_idle();
    if (mismatches == 0 && expected_rects.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/grc_pkg.sv
rtl/grc_ram.sv
rtl/grc_cfg.sv
rtl/grc_span.sv
rtl/greedy_rect_cover_top.sv
rtl/grc_checker.sv
test/greedy_rect_cover_top_tb.sv
